FILE: hdl/suwf_pkg.sv
// ----------------------------------------------------------------------------
// suwf_pkg
// Shared widths, defaults and the scan status type of the window finder.
// ----------------------------------------------------------------------------
`default_nettype none

package suwf_pkg;

    localparam int IN_VALUE_W     = 32;
    localparam int OUT_IDX_W      = 10;
    localparam int DEF_MAX_LEN    = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [OUT_IDX_W-1:0] left_index;
        logic [OUT_IDX_W-1:0] right_index;
    } t_scan_status;

endpackage

`default_nettype wire

FILE: hdl/suwf_if.sv
// ----------------------------------------------------------------------------
// suwf_in_if / suwf_out_if
// Valid/ready channels for sequence elements and window results.
// ----------------------------------------------------------------------------
`default_nettype none

interface suwf_in_if;
    import suwf_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [IN_VALUE_W-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface suwf_out_if;
    import suwf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_IDX_W-1:0] left_index;
    logic [OUT_IDX_W-1:0] right_index;

    modport source (output valid, output found, output left_index, output right_index,
                    input ready);
    modport sink   (input valid, input found, input left_index, input right_index,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/suwf_ram.sv
// ----------------------------------------------------------------------------
// suwf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module suwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/suwf_scan.sv
// ----------------------------------------------------------------------------
// suwf_scan
// Scan sequencer: streams stored keys through the RAM read port over up to five
// passes (first descent, last descent, min/max, left and right widening).
// ----------------------------------------------------------------------------
`default_nettype none

module suwf_scan #(
    parameter int MAX_LEN    = suwf_pkg::DEF_MAX_LEN,
    parameter int DATA_WIDTH = suwf_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]     i_n,
    output logic                                  o_rd_en,
    output logic      [$clog2(MAX_LEN)-1:0]       o_rd_addr,
    input  wire logic [DATA_WIDTH-1:0]            i_rd_data,
    output suwf_pkg::t_scan_status                o_status
);
    import suwf_pkg::*;

    localparam int AW     = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int WIDE_W = (AW > OUT_IDX_W) ? AW : OUT_IDX_W;

    typedef enum logic [5:0] {
        SC_IDLE   = 6'b000001,
        SC_FWD    = 6'b000010,
        SC_BWD    = 6'b000100,
        SC_MINMAX = 6'b001000,
        SC_EXTL   = 6'b010000,
        SC_EXTR   = 6'b100000
    } t_scan_state;

    t_scan_state            r_state, n_state;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic                   r_more, n_more;
    logic                   r_v, n_v;
    logic [AW-1:0]          r_vaddr, n_vaddr;
    logic [AW-1:0]          r_last, n_last;
    logic [AW-1:0]          r_left, n_left;
    logic [AW-1:0]          r_right, n_right;
    logic [DATA_WIDTH-1:0]  r_prev, n_prev;
    logic [DATA_WIDTH-1:0]  r_min, n_min;
    logic [DATA_WIDTH-1:0]  r_max, n_max;
    logic                   r_done, n_done;
    logic                   r_found, n_found;
    logic [OUT_IDX_W-1:0]   r_lo, n_lo;
    logic [OUT_IDX_W-1:0]   r_ro, n_ro;

    logic                   issue;
    logic                   jump;
    logic                   up_dir;
    logic [DATA_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0]  mn;
    logic [DATA_WIDTH-1:0]  mx;
    logic [WIDE_W-1:0]      w_left;
    logic [WIDE_W-1:0]      w_idx;

    assign key    = i_rd_data;
    assign issue  = r_more && (r_state != SC_IDLE);
    assign up_dir = r_state inside {SC_FWD, SC_MINMAX, SC_EXTL};
    assign mn     = (key < r_min) ? key : r_min;
    assign mx     = (key > r_max) ? key : r_max;
    assign w_left = WIDE_W'(r_left);
    assign w_idx  = WIDE_W'(r_vaddr);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_more  = r_more;
        n_v     = 1'b0;
        n_vaddr = r_ptr;
        n_last  = r_last;
        n_left  = r_left;
        n_right = r_right;
        n_prev  = r_prev;
        n_min   = r_min;
        n_max   = r_max;
        n_done  = 1'b0;
        n_found = r_found;
        n_lo    = r_lo;
        n_ro    = r_ro;
        jump    = 1'b0;

        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_found = 1'b0;
                    n_lo    = '0;
                    n_ro    = '0;
                    if (i_n < CNT_W'(2)) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = SC_FWD;
                        n_ptr   = '0;
                        n_more  = 1'b1;
                        n_last  = AW'(i_n - CNT_W'(1));
                    end
                end
            end
            SC_FWD: begin
                if (r_v) begin
                    n_prev = key;
                    if (r_vaddr != '0 && key < r_prev) begin
                        n_left  = r_vaddr - AW'(1);
                        n_state = SC_BWD;
                        n_ptr   = r_last;
                        n_more  = 1'b1;
                        jump    = 1'b1;
                    end else if (r_vaddr == r_last) begin
                        n_state = SC_IDLE;
                        n_more  = 1'b0;
                        n_done  = 1'b1;
                        jump    = 1'b1;
                    end
                end
            end
            SC_BWD: begin
                if (r_v) begin
                    n_prev = key;
                    if (r_vaddr != r_last && key > r_prev) begin
                        n_right = r_vaddr + AW'(1);
                        n_state = SC_MINMAX;
                        n_ptr   = r_left;
                        n_more  = 1'b1;
                        n_min   = '1;
                        n_max   = '0;
                        jump    = 1'b1;
                    end
                end
            end
            SC_MINMAX: begin
                if (r_v) begin
                    n_min = mn;
                    n_max = mx;
                    if (r_vaddr == r_right) begin
                        n_state = SC_EXTL;
                        n_ptr   = '0;
                        n_more  = 1'b1;
                        jump    = 1'b1;
                    end
                end
            end
            SC_EXTL: begin
                if (r_v && key > r_min) begin
                    n_left  = r_vaddr;
                    n_state = SC_EXTR;
                    n_ptr   = r_last;
                    n_more  = 1'b1;
                    jump    = 1'b1;
                end
            end
            SC_EXTR: begin
                if (r_v && key < r_max) begin
                    n_right = r_vaddr;
                    n_state = SC_IDLE;
                    n_more  = 1'b0;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_lo    = w_left[OUT_IDX_W-1:0];
                    n_ro    = w_idx[OUT_IDX_W-1:0];
                    jump    = 1'b1;
                end
            end
            default: begin
                n_state = SC_IDLE;
                n_more  = 1'b0;
            end
        endcase

        if (!jump && issue) begin
            n_v     = 1'b1;
            n_vaddr = r_ptr;
            if (up_dir) begin
                if (r_ptr == r_last) begin
                    n_more = 1'b0;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end else begin
                if (r_ptr == '0) begin
                    n_more = 1'b0;
                end else begin
                    n_ptr = r_ptr - AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_more  <= 1'b0;
            r_v     <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_lo    <= '0;
            r_ro    <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
            r_v     <= n_v;
            r_done  <= n_done;
            r_found <= n_found;
            r_lo    <= n_lo;
            r_ro    <= n_ro;
            r_left  <= n_left;
            r_right <= n_right;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_vaddr <= n_vaddr;
        r_last  <= n_last;
        r_prev  <= n_prev;
    end

    assign o_rd_en               = issue;
    assign o_rd_addr             = r_ptr;
    assign o_status.done         = r_done;
    assign o_status.found        = r_found;
    assign o_status.left_index   = r_lo;
    assign o_status.right_index  = r_ro;

`ifndef SYNTHESIS
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> o_rd_addr <= r_last)
        else $error("read beyond the stored sequence");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_found) |-> r_left <= r_right)
        else $error("window left above right");
    a_sorted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_found) |-> (r_lo == '0 && r_ro == '0))
        else $error("sorted result with nonzero indices");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == SC_IDLE && !r_v))
        else $error("done while scan still active");
`endif

endmodule

`default_nettype wire

FILE: hdl/shortest_unsorted_window_finder.sv
// ----------------------------------------------------------------------------
// shortest_unsorted_window_finder
// Loads a signed sequence and reports the shortest window that, once sorted,
// leaves the whole sequence non-decreasing.
// ----------------------------------------------------------------------------
// Elements load at one item per cycle, while the input is ready, into a single
// RAM; elements past MAX_LEN are dropped, and the item with last set closes the
// sequence. The search then streams stored elements through the one RAM read
// port, one read per cycle within each pass, over up to five passes; the input
// stays not ready until the result is placed in the output register.
// A sorted sequence, including one of a single element, reports found low with
// both indices zero. The store needs no clearing after reset: only entries
// written for the current sequence are read.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_unsorted_window_finder #(
    parameter int MAX_LEN    = suwf_pkg::DEF_MAX_LEN,
    parameter int DATA_WIDTH = suwf_pkg::DEF_DATA_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    suwf_in_if.sink     i_in,
    suwf_out_if.source  o_out
);
    import suwf_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int EXT_W = (DATA_WIDTH > IN_VALUE_W) ? DATA_WIDTH : IN_VALUE_W;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_top_state;

    t_top_state             r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_n, n_n;
    logic                   r_start, n_start;
    logic                   r_oval, n_oval;
    logic                   r_found;
    logic [OUT_IDX_W-1:0]   r_lo;
    logic [OUT_IDX_W-1:0]   r_ro;

    logic                   accept;
    logic                   wr_en;
    logic [EXT_W-1:0]       ext;
    logic [DATA_WIDTH-1:0]  key;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [DATA_WIDTH-1:0]  rd_data;
    logic                   load_out;
    t_scan_status           status;

    assign accept = i_in.valid && (r_state == ST_LOAD);
    assign wr_en  = accept && (r_count < CNT_W'(MAX_LEN));
    assign ext    = EXT_W'($unsigned(i_in.value));
    assign key    = ext[DATA_WIDTH-1:0] ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};
    assign load_out = (r_state == ST_EMIT) && (!r_oval || o_out.ready);

    suwf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    suwf_scan #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_n       (r_n),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_status  (status)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_start = 1'b0;
        n_oval  = r_oval && !o_out.ready;

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_count = r_count + CNT_W'(wr_en);
                    if (i_in.last) begin
                        n_n     = r_count + CNT_W'(wr_en);
                        n_count = '0;
                        n_start = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    n_oval  = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_n     <= '0;
            r_start <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_start <= n_start;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_found <= status.found;
            r_lo    <= status.left_index;
            r_ro    <= status.right_index;
        end
    end

    assign i_in.ready        = (r_state == ST_LOAD);
    assign o_out.valid       = r_oval;
    assign o_out.found       = r_found;
    assign o_out.left_index  = r_lo;
    assign o_out.right_index = r_ro;

endmodule

`default_nettype wire
